// File: hdl/bitmap_font_text_blitter_core_macros.svh
// Assertion macros shared by the checker of the text blitter.
`ifndef BITMAP_FONT_TEXT_BLITTER_CORE_MACROS_SVH
`define BITMAP_FONT_TEXT_BLITTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BFTB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blitter check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BFTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blitter check failed");

`endif

// File: hdl/bftb_pkg.sv
// Types and constants shared by the text blitter modules.
`default_nettype none

package bftb_pkg;

    localparam int GLYPH_GRID  = 16;
    localparam int GLYPH_ROWS  = 16;
    localparam int ROW_W       = 4;
    localparam int CODE_W      = 8;
    localparam int ADDR_W      = CODE_W + ROW_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_COLOR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALIGNMENT   = 3'd5;

    // Configuration after limiting to the supported ranges.
    typedef struct packed {
        logic [3:0]  cw;
        logic [4:0]  ch;
        logic [10:0] dw;
        logic [10:0] dh;
        logic [31:0] color;
        logic [1:0]  align;
    } cfg_t;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  grow;
        logic [7:0]        bits;
        logic [13:0]       pen_x;
        logic [11:0]       pen_y;
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/bitmap_font_text_blitter_core.sv
// Top level of the bitmap font text blitter: configuration, front end, queue, back end.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  input   | in        | in_valid / in_stall | operation .. string_length
//  output  | out       | out_valid/out_stall | glyph_x, row_y, pixel_mask, pixel_color,
//          |           |                     | last_row
//  config  | in        | cfg_we              | cfg_index, cfg_data
//
// The front end takes one item per cycle while the four-entry command queue has room.
// A glyph row load is written to the glyph store when popped. A draw passes a setup
// state, then reads its visible glyph rows (up to 16) in turn through the single glyph
// store read port, held while the output stalls; a fully clipped character stops after setup and emits nothing.
// Reset clears the pen, the queue and all valid flags; the glyph store is not cleared.
// An output stall freezes the read stage and the output register; the queue absorbs input.
`default_nettype none

module bitmap_font_text_blitter_core #(
    parameter int MAX_CHAR_WIDTH  = 8,
    parameter int MAX_CHAR_HEIGHT = 16,
    parameter int MAX_DEST_SIZE   = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  character_code,
    input  wire logic [3:0]  glyph_row,
    input  wire logic [7:0]  row_bits,
    input  wire logic        first_of_string,
    input  wire logic [11:0] pos_x,
    input  wire logic [11:0] pos_y,
    input  wire logic [7:0]  string_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [13:0]      glyph_x,
    output logic [12:0]      row_y,
    output logic [7:0]       pixel_mask,
    output logic [31:0]      pixel_color,
    output logic             last_row
);

    localparam int CW_LIM = (MAX_CHAR_WIDTH < 8) ? MAX_CHAR_WIDTH : 8;
    localparam int CH_LIM = (MAX_CHAR_HEIGHT < bftb_pkg::GLYPH_ROWS) ? MAX_CHAR_HEIGHT
                                                                     : bftb_pkg::GLYPH_ROWS;

    logic [3:0]  char_width_reg;
    logic [4:0]  char_height_reg;
    logic [10:0] dest_width_reg;
    logic [10:0] dest_height_reg;
    logic [31:0] draw_color_reg;
    logic [1:0]  alignment_reg;

    bftb_pkg::cfg_t cfg;
    bftb_pkg::cmd_t push_cmd;
    bftb_pkg::cmd_t q_head;
    logic push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_width_reg  <= 4'd8;
            char_height_reg <= 5'd12;
            dest_width_reg  <= 11'd1024;
            dest_height_reg <= 11'd1024;
            draw_color_reg  <= '0;
            alignment_reg   <= bftb_pkg::ALIGN_LEFT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bftb_pkg::REG_CHAR_WIDTH:  char_width_reg  <= cfg_data[3:0];
                bftb_pkg::REG_CHAR_HEIGHT: char_height_reg <= cfg_data[4:0];
                bftb_pkg::REG_DEST_WIDTH:  dest_width_reg  <= cfg_data[10:0];
                bftb_pkg::REG_DEST_HEIGHT: dest_height_reg <= cfg_data[10:0];
                bftb_pkg::REG_DRAW_COLOR:  draw_color_reg  <= cfg_data;
                bftb_pkg::REG_ALIGNMENT:   alignment_reg   <= cfg_data[1:0];
                default:                   ;
            endcase
        end
    end

    // Limit the registers to what the datapath supports.
    always_comb
    begin
        cfg.cw    = (char_width_reg > 4'(CW_LIM)) ? 4'(CW_LIM) : char_width_reg;
        cfg.ch    = (char_height_reg > 5'(CH_LIM)) ? 5'(CH_LIM) : char_height_reg;
        cfg.dw    = ({2'b00, dest_width_reg} > 13'(MAX_DEST_SIZE)) ? 11'(MAX_DEST_SIZE)
                                                                   : dest_width_reg;
        cfg.dh    = ({2'b00, dest_height_reg} > 13'(MAX_DEST_SIZE)) ? 11'(MAX_DEST_SIZE)
                                                                    : dest_height_reg;
        cfg.color = draw_color_reg;
        cfg.align = alignment_reg;
    end

    bftb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .character_code  (character_code),
        .glyph_row       (glyph_row),
        .row_bits        (row_bits),
        .first_of_string (first_of_string),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .string_length   (string_length),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    bftb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    bftb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .glyph_x     (glyph_x),
        .row_y       (row_y),
        .pixel_mask  (pixel_mask),
        .pixel_color (pixel_color),
        .last_row    (last_row)
    );

endmodule

`default_nettype wire

// File: hdl/bftb_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module bftb_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  bftb_pkg::cmd_t    push_cmd,
    output logic              full,
    input  wire logic         pop,
    output bftb_pkg::cmd_t    head,
    output logic              empty
);

    localparam int PTR_W = $clog2(bftb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bftb_pkg::QUEUE_DEPTH + 1);

    bftb_pkg::cmd_t entry_reg [bftb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == CNT_W'(bftb_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bftb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bftb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bftb_front.sv
// Front end: accepts items, places the pen and queues load and draw commands.
`default_nettype none

module bftb_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bftb_pkg::cfg_t    cfg,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         operation,
    input  wire logic [7:0]   character_code,
    input  wire logic [3:0]   glyph_row,
    input  wire logic [7:0]   row_bits,
    input  wire logic         first_of_string,
    input  wire logic [11:0]  pos_x,
    input  wire logic [11:0]  pos_y,
    input  wire logic [7:0]   string_length,
    input  wire logic         q_full,
    output logic              push,
    output bftb_pkg::cmd_t    cmd
);

    logic [13:0] pen_x_reg, pen_x_next;
    logic [11:0] pen_y_reg, pen_y_next;
    logic [11:0] span;
    logic [11:0] offset;
    logic [13:0] start_x;
    logic [13:0] pen_x_eff;
    logic [11:0] pen_y_eff;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        span = 12'(string_length) * 12'(cfg.cw);
        unique case (cfg.align)
            bftb_pkg::ALIGN_CENTER: offset = span >> 1;
            bftb_pkg::ALIGN_RIGHT:  offset = span;
            default:                offset = '0;
        endcase
        start_x   = {{2{pos_x[11]}}, pos_x} - {2'b00, offset};
        pen_x_eff = first_of_string ? start_x : pen_x_reg;
        pen_y_eff = first_of_string ? pos_y : pen_y_reg;

        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (push && (operation == bftb_pkg::OP_DRAW))
        begin
            pen_x_next = pen_x_eff + {10'd0, cfg.cw};
            pen_y_next = pen_y_eff;
        end

        cmd.op    = operation;
        cmd.code  = character_code;
        cmd.grow  = glyph_row;
        cmd.bits  = row_bits;
        cmd.pen_x = pen_x_eff;
        cmd.pen_y = pen_y_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bftb_back.sv
// Back end: owns the glyph store, walks visible glyph rows and drives results.
`default_nettype none

module bftb_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bftb_pkg::cfg_t    cfg,
    input  wire logic         q_empty,
    input  bftb_pkg::cmd_t    q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [13:0]       glyph_x,
    output logic [12:0]       row_y,
    output logic [7:0]        pixel_mask,
    output logic [31:0]       pixel_color,
    output logic              last_row
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    typedef struct packed {
        logic [13:0] x;
        logic [12:0] y;
        logic [7:0]  colmask;
        logic        last;
    } stage_t;

    localparam int DEPTH = 1 << bftb_pkg::ADDR_W;

    logic [7:0] glyph_mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic [1:0]  state_reg, state_next;
    bftb_pkg::cmd_t cmd_reg;
    logic [3:0]  r_reg, r_next;
    logic [3:0]  rhi_reg, rhi_next;
    logic [7:0]  colmask_reg, colmask_next;

    logic        s1_valid_reg, s1_valid_next;
    stage_t      s1_reg, s1_next;
    logic        out_valid_reg, out_valid_next;

    logic        adv;
    logic        issue;
    logic        wr_en;
    logic [bftb_pkg::ADDR_W-1:0] wr_addr;
    logic [bftb_pkg::ADDR_W-1:0] rd_addr;

    logic signed [14:0] py15;
    logic signed [14:0] px15;
    logic signed [14:0] dw15;
    logic signed [14:0] row_lo;
    logic signed [14:0] hi_h;
    logic signed [14:0] hi_d;
    logic signed [14:0] row_hi;
    logic signed [14:0] xt;
    logic        rows_vis;

    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en = q_pop && (q_head.op == bftb_pkg::OP_LOAD);
    assign wr_addr = {q_head.code, q_head.grow};
    assign issue   = (state_reg == ST_RUN) && adv;
    assign rd_addr = {cmd_reg.code, r_reg};

    // Visible row window and column mask of the current character.
    always_comb
    begin
        py15   = {{3{cmd_reg.pen_y[11]}}, cmd_reg.pen_y};
        px15   = {cmd_reg.pen_x[13], cmd_reg.pen_x};
        dw15   = {4'd0, cfg.dw};
        row_lo = py15[14] ? -py15 : 15'sd0;
        hi_h   = $signed({10'd0, cfg.ch}) - 15'sd1;
        hi_d   = $signed({4'd0, cfg.dh}) - 15'sd1 - py15;
        row_hi = (hi_h < hi_d) ? hi_h : hi_d;
        colmask_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            xt = px15 + 15'(i);
            colmask_next[i] = (4'(i) < cfg.cw) && !xt[14] && (xt < dw15);
        end
        rows_vis = (colmask_next != '0) && (row_lo <= row_hi);
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        rhi_next   = rhi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_head.op == bftb_pkg::OP_DRAW))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                r_next     = row_lo[3:0];
                rhi_next   = row_hi[3:0];
                state_next = rows_vis ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (r_reg == rhi_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read stage and output register advance together so a stall freezes both.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            s1_valid_next  = issue;
            out_valid_next = s1_valid_reg;
            s1_next.x       = cmd_reg.pen_x;
            s1_next.y       = {cmd_reg.pen_y[11], cmd_reg.pen_y} + {9'd0, r_reg};
            s1_next.colmask = colmask_reg;
            s1_next.last    = (r_reg == rhi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        rhi_reg <= rhi_next;
        s1_reg  <= s1_next;
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (state_reg == ST_SETUP)
        begin
            colmask_reg <= colmask_next;
        end
        if (adv && s1_valid_reg)
        begin
            glyph_x     <= s1_reg.x;
            row_y       <= s1_reg.y;
            pixel_mask  <= rd_data_reg & s1_reg.colmask;
            pixel_color <= cfg.color;
            last_row    <= s1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_addr] <= q_head.bits;
        end
        if (issue)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/bftb_checker.sv
// Port-level checks of the text blitter and the bind that attaches them.
`default_nettype none

`include "bitmap_font_text_blitter_core_macros.svh"

module bftb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [13:0] glyph_x,
    input wire logic [12:0] row_y,
    input wire logic [7:0]  pixel_mask,
    input wire logic        last_row
);

    // A held result keeps its payload.
    `BFTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(glyph_x) && $stable(row_y) && $stable(pixel_mask) && $stable(last_row))

    // Rows above the raster are clipped away, so no result has a negative row.
    `BFTB_ASSERT_IMPL(a_row_visible, out_valid, !row_y[12])

    // With the pen left of the raster, glyph column zero is always clipped.
    `BFTB_ASSERT_IMPL(a_left_clip, out_valid && glyph_x[13], !pixel_mask[0])

    // Rows of one character follow each other without a gap, one row apart.
    `BFTB_ASSERT_NEXT(a_rows_follow, out_valid && !out_stall && !last_row, out_valid && (row_y == $past(row_y) + 13'd1))

endmodule

bind bitmap_font_text_blitter_core bftb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .glyph_x    (glyph_x),
    .row_y      (row_y),
    .pixel_mask (pixel_mask),
    .last_row   (last_row)
);

`default_nettype wire
